>>> src/pcm_sample_decode_downmix_macros.svh
// Assertion macros shared by the checker of the PCM sample decoder.
`ifndef PCM_SAMPLE_DECODE_DOWNMIX_MACROS_SVH
`define PCM_SAMPLE_DECODE_DOWNMIX_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PSDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after reset is applied.
`define PSDD_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

>>> src/psdd_pkg.sv
// Shared types, constants and helper functions of the PCM sample decoder.
`timescale 1ns / 1ps
package psdd_pkg;

  localparam int unsigned DEF_MAX_CHANNELS = 8;
  localparam int unsigned DEF_FRAC_BITS    = 23;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned OUT_BITS         = 24;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_8    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS      = 3'd4;

  typedef struct packed {
    logic [6:0] sample_bits;
    logic       float_samples;
    logic       big_endian_order;
    logic       unsigned_eight_bit;
    logic [3:0] channel_count;
  } psdd_cfg_t;

  // One assembled sample on its way from the front to the back.
  typedef struct packed {
    logic [63:0] raw;
    logic        first;
    logic        frame_end;
    logic        last;
  } psdd_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_ACC,
    BK_DIV,
    BK_MUL,
    BK_FIX
  } psdd_back_state_t;

  // Bytes consumed per sample, held to 1..8.
  function automatic logic [3:0] sample_byte_count(input logic [6:0] sb);
    logic [3:0] nb;
    nb = sb[6:3];
    if (nb == 4'd0) nb = 4'd1;
    if (nb > 4'd8) nb = 4'd8;
    return nb;
  endfunction

  // Channel count with zero read as one and large values held to the maximum.
  function automatic logic [3:0] eff_channels(input logic [3:0] cc, input logic [3:0] maxc);
    logic [3:0] nc;
    nc = cc;
    if (nc == 4'd0) nc = 4'd1;
    if (nc > maxc) nc = maxc;
    return nc;
  endfunction

endpackage

>>> src/pcm_sample_decode_downmix.sv
// Top level of the PCM sample decoder with mono downmix.
//
// Usage: bytes of an interleaved PCM data chunk enter on the in_ channel, one
// item per accepted byte, with in_end_of_data marking the final byte. Each
// complete frame gives one item on the out_ channel: the channel average in
// signed Q1.23, a flag for saturated float values and a flag for the frame
// that ended on the final byte. A partial frame at the end is dropped.
// The cfg_ channel writes the five format registers by index; it is always
// ready, and any write to a known register also restarts frame assembly.
// A result is registered once the byte ending a frame has passed the queue and the
// back's shift, accumulate, divide, multiply and fix states. The front takes one
// byte per cycle while the queue is not full; the back divides only at a frame end,
// so a two-entry sample queue absorbs bursts and in_stall rises when it is full.
// Reset clears the frame state, the queue and the output valid flag and loads
// the register defaults (16-bit signed little endian integer, one channel).
// While out_stall is high the current result holds and the back waits before
// its next result, so the queue fills and in turn stalls the input.
`timescale 1ns / 1ps
module pcm_sample_decode_downmix #(
  parameter int unsigned MAX_CHANNELS = psdd_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned FRAC_BITS    = psdd_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_data_byte,
  input  logic                                  in_end_of_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psdd_pkg::OUT_BITS-1:0]  out_mono_sample,
  output logic                                  out_clipped,
  output logic                                  out_last_frame,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psdd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [7:0]                            cfg_data
);
  import psdd_pkg::*;

  psdd_cfg_t   cfg_r, cfg_nxt;
  logic        cfg_hit;
  logic        q_push, q_pop, q_empty, q_full;
  psdd_entry_t q_in, q_head;

  assign cfg_ready = 1'b1;

  // Register file; unknown indices are ignored and do not restart a frame.
  always_comb begin
    cfg_nxt = cfg_r;
    cfg_hit = 1'b0;
    if (cfg_valid && cfg_ready) begin
      cfg_hit = 1'b1;
      unique case (cfg_index)
        REG_SAMPLE_BITS:   cfg_nxt.sample_bits        = cfg_data[6:0];
        REG_FLOAT_SAMPLES: cfg_nxt.float_samples      = cfg_data[0];
        REG_BIG_ENDIAN:    cfg_nxt.big_endian_order   = cfg_data[0];
        REG_UNSIGNED_8:    cfg_nxt.unsigned_eight_bit = cfg_data[0];
        REG_CHANNELS:      cfg_nxt.channel_count      = cfg_data[3:0];
        default:           cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sample_bits: 7'd16, float_samples: 1'b0, big_endian_order: 1'b0,
                 unsigned_eight_bit: 1'b1, channel_count: 4'd1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  psdd_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cfg_wr     (cfg_hit),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (in_data_byte),
    .end_of_data(in_end_of_data),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  psdd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  psdd_back #(.MAX_CHANNELS(MAX_CHANNELS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mono_sample(out_mono_sample),
    .clipped    (out_clipped),
    .last_frame (out_last_frame)
  );

endmodule

>>> src/psdd_front.sv
// Front end: assembles bytes into samples and tags frame boundaries.
`timescale 1ns / 1ps
module psdd_front #(
  parameter int unsigned MAX_CHANNELS = psdd_pkg::DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psdd_pkg::psdd_cfg_t   cfg,
  input  logic                  cfg_wr,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_data,
  input  logic                  q_full,
  output logic                  push,
  output psdd_pkg::psdd_entry_t push_entry
);
  import psdd_pkg::*;

  localparam int unsigned MAXC = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
  localparam int unsigned CPW  = (MAXC > 1) ? $clog2(MAXC) : 1;

  logic [63:0]    bytes_r, bytes_nxt, bytes_cat;
  logic [2:0]     bpos_r, bpos_nxt;
  logic [CPW-1:0] ch_r, ch_nxt;
  logic [3:0]     nb, nc;
  logic           accept, done, frame_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign nb       = sample_byte_count(cfg.sample_bits);
  assign nc       = eff_channels(cfg.channel_count, 4'(MAXC));

  always_comb begin
    if (cfg.big_endian_order) begin
      bytes_cat = {bytes_r[55:0], data_byte};
    end else begin
      bytes_cat = bytes_r | (64'(data_byte) << {bpos_r, 3'b000});
    end
    done       = ({1'b0, bpos_r} + 4'd1) >= nb;
    frame_done = (5'(ch_r) + 5'd1) >= {1'b0, nc};
    push       = accept && done;
    push_entry = '{raw: bytes_cat, first: (ch_r == '0), frame_end: frame_done,
                   last: end_of_data};
  end

  always_comb begin
    bytes_nxt = bytes_r;
    bpos_nxt  = bpos_r;
    ch_nxt    = ch_r;
    if (cfg_wr || (accept && end_of_data)) begin
      bytes_nxt = '0;
      bpos_nxt  = '0;
      ch_nxt    = '0;
    end else if (accept) begin
      if (done) begin
        bytes_nxt = '0;
        bpos_nxt  = '0;
        ch_nxt    = frame_done ? '0 : CPW'(ch_r + 1'b1);
      end else begin
        bytes_nxt = bytes_cat;
        bpos_nxt  = bpos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      bpos_r  <= '0;
      ch_r    <= '0;
    end else begin
      bytes_r <= bytes_nxt;
      bpos_r  <= bpos_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

>>> src/psdd_queue.sv
// Short sample queue between the front end and the back end.
`timescale 1ns / 1ps
module psdd_queue #(
  parameter int unsigned DEPTH = psdd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  psdd_pkg::psdd_entry_t push_entry,
  input  logic                  pop,
  output psdd_pkg::psdd_entry_t head,
  output logic                  empty,
  output logic                  full
);
  import psdd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  psdd_entry_t    slots_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = slots_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (push && !pop) cnt_nxt = CW'(cnt_r + 1'b1);
    if (pop && !push) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/psdd_back.sv
// Back end: converts samples to fixed point, sums a frame and averages it.
`timescale 1ns / 1ps
module psdd_back #(
  parameter int unsigned MAX_CHANNELS = psdd_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned FRAC_BITS    = psdd_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psdd_pkg::psdd_cfg_t               cfg,
  input  psdd_pkg::psdd_entry_t             head,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [psdd_pkg::OUT_BITS-1:0] mono_sample,
  output logic                              clipped,
  output logic                              last_frame
);
  import psdd_pkg::*;

  localparam int unsigned MAXC = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
  localparam int unsigned VW   = FRAC_BITS + 2;
  localparam int unsigned SUMW = FRAC_BITS + 1 + $clog2(MAXC + 1);
  localparam logic [63:0] FULL = 64'd1 << FRAC_BITS;
  localparam logic [VW-1:0] POS_MAX  = VW'(FULL - 64'd1);
  localparam logic [VW-1:0] NEG_FULL = VW'(64'd0 - FULL);
  localparam logic [SUMW:0] ONE = (SUMW + 1)'(1) << SUMW;
  // floor(2^SUMW / n); the quotient from it is at most one short.
  localparam logic [SUMW:0] RECIP [16] = '{{(SUMW + 1){1'b0}}, ONE / 1, ONE / 2,
    ONE / 3, ONE / 4, ONE / 5, ONE / 6, ONE / 7, ONE / 8, ONE / 9, ONE / 10,
    ONE / 11, ONE / 12, ONE / 13, ONE / 14, ONE / 15};

  psdd_back_state_t state_r, state_nxt;

  logic                   ld_prep, ld_val, ld_acc, ld_div, ld_mul, ld_out, slot_free;
  logic [3:0]             nc;

  // Decode preparation, taken from the queue head.
  logic                   p_spec, p_neg, p_clip;
  logic [VW-1:0]          p_spec_val;
  logic [63:0]            p_mag;
  logic signed [12:0]     p_sh;
  logic                   spec_r, neg_r, clip_r, first_r, end_r, last_r;
  logic [VW-1:0]          spec_val_r;
  logic [63:0]            mag_r;
  logic signed [12:0]     sh_r;

  logic signed [VW-1:0]   val_r;
  logic                   vclip_r, vfirst_r;
  logic signed [SUMW-1:0] sum_r;
  logic                   csum_r;
  logic [SUMW-1:0]        x_r, q0_r, abs_sum, rem, q;
  logic [2*SUMW:0]        prod;
  logic signed [63:0]     avg;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]    out_sample_r;
  logic                   out_clip_r, out_last_r;

  assign nc = eff_channels(cfg.channel_count, 4'(MAXC));

  function automatic logic [VW-1:0] to_fixed(input logic [63:0] mag,
                                            input logic signed [12:0] sh,
                                            input logic neg);
    logic [63:0] r;
    logic [12:0] k;
    k = 13'(-sh);
    if (!sh[12]) begin
      r = mag << sh[11:0];
    end else if (k >= 13'd60) begin
      r = '0;
    end else begin
      r = (mag + (64'd1 << (k - 13'd1))) >> k;
    end
    if (!neg) begin
      if (r > FULL - 64'd1) r = FULL - 64'd1;
      return VW'(r);
    end
    if (r > FULL) r = FULL;
    return VW'(64'd0 - r);
  endfunction

  // Field extraction and special cases of one sample.
  always_comb begin
    logic [10:0] e, emax, bias, e1;
    logic [51:0] m;
    logic [12:0] ofs;
    logic [63:0] rawm;
    p_spec     = 1'b1;
    p_spec_val = '0;
    p_neg      = 1'b0;
    p_clip     = 1'b0;
    p_mag      = '0;
    p_sh       = '0;
    e = '0; emax = '0; bias = '0; m = '0; ofs = '0; e1 = '0;
    rawm = '0;
    if (cfg.float_samples && (cfg.sample_bits == 7'd32 || cfg.sample_bits == 7'd64)) begin
      if (cfg.sample_bits == 7'd64) begin
        p_neg = head.raw[63];
        e     = head.raw[62:52];
        m     = head.raw[51:0];
        emax  = 11'd2047;
        bias  = 11'd1023;
        ofs   = 13'd1075;
        p_mag = 64'(m) | (64'd1 << 52);
      end else begin
        p_neg = head.raw[31];
        e     = {3'b000, head.raw[30:23]};
        m     = {29'd0, head.raw[22:0]};
        emax  = 11'd255;
        bias  = 11'd127;
        ofs   = 13'd150;
        p_mag = 64'(m) | (64'd1 << 23);
      end
      if (e == emax) begin
        p_spec_val = '0;
      end else if (e >= bias) begin
        if (p_neg && e == bias && m == '0) begin
          p_spec_val = NEG_FULL;
        end else begin
          p_clip     = 1'b1;
          p_spec_val = p_neg ? NEG_FULL : POS_MAX;
        end
      end else begin
        p_spec = 1'b0;
        if (e == '0) p_mag = 64'(m);
        e1   = (e == '0) ? 11'd1 : e;
        p_sh = $signed({2'b00, e1}) - $signed(ofs) + $signed(13'(FRAC_BITS));
      end
    end else if (!cfg.float_samples && (cfg.sample_bits == 7'd8 ||
                 cfg.sample_bits == 7'd16 || cfg.sample_bits == 7'd24 ||
                 cfg.sample_bits == 7'd32)) begin
      p_spec = 1'b0;
      rawm   = head.raw & ((64'd1 << cfg.sample_bits) - 64'd1);
      if (cfg.sample_bits == 7'd8 && cfg.unsigned_eight_bit) rawm[7] = ~rawm[7];
      p_neg  = rawm[6'(cfg.sample_bits - 7'd1)];
      p_mag  = p_neg ? (64'd1 << cfg.sample_bits) - rawm : rawm;
      p_sh   = $signed(13'(FRAC_BITS)) - $signed(13'(cfg.sample_bits - 7'd1));
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = BK_SHIFT;
      BK_SHIFT: state_nxt = BK_ACC;
      BK_ACC:   state_nxt = end_r ? BK_DIV : BK_IDLE;
      BK_DIV:   state_nxt = BK_MUL;
      BK_MUL:   state_nxt = BK_FIX;
      BK_FIX:   if (slot_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    ld_prep = 1'b0;
    ld_val  = 1'b0;
    ld_acc  = 1'b0;
    ld_div  = 1'b0;
    ld_mul  = 1'b0;
    ld_out  = 1'b0;
    unique case (state_r)
      BK_IDLE:  ld_prep = !q_empty;
      BK_SHIFT: ld_val  = 1'b1;
      BK_ACC:   ld_acc  = 1'b1;
      BK_DIV:   ld_div  = 1'b1;
      BK_MUL:   ld_mul  = 1'b1;
      BK_FIX:   ld_out  = slot_free;
      default:  ld_prep = 1'b0;
    endcase
  end

  assign pop       = ld_prep;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    abs_sum = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
    prod    = (2 * SUMW + 1)'(x_r) * (2 * SUMW + 1)'(RECIP[nc]);
    rem     = SUMW'(x_r - SUMW'(q0_r * SUMW'(nc)));
    q       = (rem >= SUMW'(nc)) ? SUMW'(q0_r + 1'b1) : q0_r;
    avg     = sum_r[SUMW-1] ? 64'sd0 - $signed(64'(q)) : $signed(64'(q));
    out_valid_nxt = ld_out ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (ld_prep) begin
      spec_r     <= p_spec;
      spec_val_r <= p_spec_val;
      mag_r      <= p_mag;
      sh_r       <= p_sh;
      neg_r      <= p_neg;
      clip_r     <= p_clip;
      first_r    <= head.first;
      end_r      <= head.frame_end;
      last_r     <= head.last;
    end
    if (ld_val) begin
      val_r    <= spec_r ? $signed(spec_val_r) : $signed(to_fixed(mag_r, sh_r, neg_r));
      vclip_r  <= clip_r;
      vfirst_r <= first_r;
    end
    if (ld_acc) begin
      sum_r  <= (vfirst_r ? '0 : sum_r) + SUMW'(val_r);
      csum_r <= (vfirst_r ? 1'b0 : csum_r) | vclip_r;
    end
    if (ld_div) x_r <= abs_sum + SUMW'(nc >> 1);
    if (ld_mul) q0_r <= prod[SUMW +: SUMW];
    if (ld_out) begin
      out_sample_r <= avg[OUT_BITS-1:0];
      out_clip_r   <= csum_r;
      out_last_r   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign mono_sample = out_sample_r;
  assign clipped     = out_clip_r;
  assign last_frame  = out_last_r;

endmodule

>>> src/psdd_checker.sv
// Port-level checker for the PCM sample decoder and its bind statement.
`timescale 1ns / 1ps
`include "pcm_sample_decode_downmix_macros.svh"
module psdd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [psdd_pkg::OUT_BITS-1:0] out_mono_sample,
  input logic                                 out_clipped,
  input logic                                 out_last_frame
);

  `PSDD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `PSDD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_mono_sample) && $stable(out_clipped) && $stable(out_last_frame), "stalled result changed")
  `PSDD_ASSERT_RESET(a_rst_out, !out_valid, "result shown after reset")
  `PSDD_ASSERT_RESET(a_rst_in, !in_stall, "input stalled after reset")

endmodule

bind pcm_sample_decode_downmix psdd_checker u_psdd_checker (.*);
